@@ hdl/bbps_pkg.sv @@
`timescale 1ns / 1ps

package bbps_pkg;

  // Counter widths
  localparam int TIME_BITS   = 16;
  localparam int REPEAT_BITS = 8;

  // Command codes
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_WARN = 2'd1,
    MODE_KEY  = 2'd2,
    MODE_MUTE = 2'd3
  } mode_t;

  // Pattern states; codes six and seven are unused
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_ON    = 3'd2,
    ST_END   = 3'd3,
    ST_OFF   = 3'd4,
    ST_DONE  = 3'd5
  } pstate_t;

  // Command word
  typedef struct packed {
    mode_t       mode;
    logic [15:0] tone_freq_in;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [7:0]  repeat_count;
    logic        mute_flag;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        busy_res;
  } res_t;

  // Sequencer state
  typedef struct packed {
    pstate_t                  pstate;
    logic [TIME_BITS-1:0]     elapsed;
    logic [15:0]              pattern_freq;
    logic [TIME_BITS-1:0]     on_time;
    logic [TIME_BITS-1:0]     off_time;
    logic [REPEAT_BITS-1:0]   beeps_left;
    logic                     muted;
    logic                     tone_active;
    logic [15:0]              applied_freq;
  } seq_state_t;

  localparam logic [REPEAT_BITS-1:0] REP_TWO = REPEAT_BITS'(2);
  localparam logic [REPEAT_BITS-1:0] REP_ONE = REPEAT_BITS'(1);

endpackage

@@ hdl/bbps_step.sv @@
`timescale 1ns / 1ps

module bbps_step (
  input  bbps_pkg::seq_state_t cur,
  input  bbps_pkg::cmd_t       cmd,
  output bbps_pkg::seq_state_t nxt,
  output bbps_pkg::res_t       res
);
  import bbps_pkg::*;

  logic [TIME_BITS-1:0] elapsed_inc;

  // Saturating tick count
  assign elapsed_inc = (cur.elapsed != '1) ? cur.elapsed + TIME_BITS'(1) : cur.elapsed;

  // Apply one command word to the state
  always_comb begin
    nxt = cur;
    case (cmd.mode)
      MODE_TICK: begin
        case (cur.pstate)
          ST_IDLE: begin
          end
          ST_START: begin
            if (!cur.muted) begin
              nxt.tone_active  = 1'b1;
              nxt.applied_freq = cur.pattern_freq;
            end
            nxt.pstate  = ST_ON;
            nxt.elapsed = '0;
          end
          ST_ON: begin
            if (elapsed_inc < cur.on_time) begin
              nxt.elapsed = elapsed_inc;
            end else begin
              nxt.pstate  = ST_END;
              nxt.elapsed = '0;
            end
          end
          ST_END: begin
            nxt.tone_active = 1'b0;
            nxt.pstate      = ST_OFF;
            nxt.elapsed     = '0;
          end
          ST_OFF: begin
            if (cur.beeps_left < REP_TWO) begin
              nxt.pstate  = ST_DONE;
              nxt.elapsed = '0;
            end else if (elapsed_inc < cur.off_time) begin
              nxt.elapsed = elapsed_inc;
            end else begin
              nxt.beeps_left = cur.beeps_left - REP_ONE;
              nxt.pstate     = ST_START;
              nxt.elapsed    = '0;
            end
          end
          ST_DONE: begin
            nxt.pattern_freq = '0;
            nxt.on_time      = '0;
            nxt.off_time     = '0;
            nxt.beeps_left   = '0;
            nxt.pstate       = ST_IDLE;
            nxt.elapsed      = '0;
          end
          default: begin
            nxt.pstate  = ST_IDLE;
            nxt.elapsed = '0;
          end
        endcase
      end
      MODE_WARN: begin
        nxt.pattern_freq = cmd.tone_freq_in;
        nxt.on_time      = TIME_BITS'(cmd.on_ms);
        nxt.off_time     = TIME_BITS'(cmd.off_ms);
        nxt.beeps_left   = REPEAT_BITS'(cmd.repeat_count);
        if (cur.pstate == ST_IDLE) begin
          nxt.pstate  = ST_START;
          nxt.elapsed = '0;
        end
      end
      MODE_KEY: begin
        nxt.pattern_freq = cmd.tone_freq_in;
        nxt.on_time      = TIME_BITS'(cmd.on_ms);
        nxt.off_time     = '0;
        nxt.beeps_left   = REP_ONE;
        nxt.pstate       = ST_START;
        nxt.elapsed      = '0;
      end
      default: begin
        nxt.muted = cmd.mute_flag;
        if (cmd.mute_flag) begin
          nxt.tone_active = 1'b0;
        end
      end
    endcase
  end

  // Form the result from the updated state
  assign res.tone_on   = nxt.tone_active;
  assign res.tone_freq = nxt.applied_freq;
  assign res.busy_res  = (nxt.pstate != ST_IDLE);

endmodule

@@ hdl/buzzer_beep_pattern_sequencer.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Word   Handshake
// cmd      in         cmd_t  cmd_valid / cmd_ready
// res      out        res_t  res_valid / res_ready
//
// One result word per command word, registered: it shows in the cycle after
// the command is taken. A command is taken every cycle while the result
// register is empty or being drained; the single result register is the
// only thing that stalls the command side.
// Synchronous reset returns the sequencer to idle and empties the result.

module buzzer_beep_pattern_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bbps_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output bbps_pkg::res_t res
);
  import bbps_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  res_t       res_next;
  logic       cmd_fire;

  assign cmd_ready = !res_valid || res_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;

  bbps_step u_step (
    .cur (state),
    .cmd (cmd),
    .nxt (state_next),
    .res (res_next)
  );

  // Advance the sequencer on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pstate       <= ST_IDLE;
      state.elapsed      <= '0;
      state.pattern_freq <= '0;
      state.on_time      <= '0;
      state.off_time     <= '0;
      state.beeps_left   <= '0;
      state.muted        <= 1'b0;
      state.tone_active  <= 1'b0;
      state.applied_freq <= '0;
    end else if (cmd_fire) begin
      state <= state_next;
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res <= res_next;
    end
  end

endmodule

@@ hdl/bbps_checker.sv @@
`timescale 1ns / 1ps

module bbps_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input bbps_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_ready,
  input bbps_pkg::res_t res
);
  import bbps_pkg::*;

  // Stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Mute stops the tone at once
  a_mute_stops: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.mode == MODE_MUTE && cmd.mute_flag
    |=> res_valid && !res.tone_on)
    else $error("tone still on after mute");

  // Keysound always starts a pattern
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.mode == MODE_KEY |=> res_valid && res.busy_res)
    else $error("keysound did not start a pattern");

  // Warn leaves the sequencer busy
  a_warn_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.mode == MODE_WARN |=> res_valid && res.busy_res)
    else $error("warn did not leave sequencer busy");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind buzzer_beep_pattern_sequencer bbps_checker u_bbps_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bbps_pkg::*;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  // Random idling controls for both sides
  bit   gap_en;
  bit   stall_en;
  int   words_sent;
  int   fail_count;

  // Predicted sequencer state
  pstate_t                seq_st;
  logic [TIME_BITS-1:0]   tick_cnt;
  logic [15:0]            beep_freq;
  logic [TIME_BITS-1:0]   beep_on;
  logic [TIME_BITS-1:0]   beep_off;
  logic [REPEAT_BITS-1:0] beeps_rem;
  logic                   is_muted;
  logic                   tone_live;
  logic [15:0]            tone_hz;

  // Result words still owed by the sequencer, oldest first
  res_t predicted_res[$];

  buzzer_beep_pattern_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #10 clk = ~clk;

  // Apply one command word to the predicted state and return the result word
  task automatic step_sequencer(input cmd_t c, output res_t r);
    case (c.mode)
      MODE_TICK: begin
        case (seq_st)
          ST_IDLE: begin
          end
          ST_START: begin
            if (!is_muted) begin
              tone_live = 1'b1;
              tone_hz   = beep_freq;
            end
            seq_st   = ST_ON;
            tick_cnt = '0;
          end
          ST_ON: begin
            if (tick_cnt != '1) tick_cnt++;
            if (tick_cnt >= beep_on) begin
              seq_st   = ST_END;
              tick_cnt = '0;
            end
          end
          ST_END: begin
            tone_live = 1'b0;
            seq_st    = ST_OFF;
            tick_cnt  = '0;
          end
          ST_OFF: begin
            if (beeps_rem < REP_TWO) begin
              seq_st   = ST_DONE;
              tick_cnt = '0;
            end else begin
              if (tick_cnt != '1) tick_cnt++;
              if (tick_cnt >= beep_off) begin
                beeps_rem--;
                seq_st   = ST_START;
                tick_cnt = '0;
              end
            end
          end
          ST_DONE: begin
            beep_freq = '0;
            beep_on   = '0;
            beep_off  = '0;
            beeps_rem = '0;
            seq_st    = ST_IDLE;
            tick_cnt  = '0;
          end
          default: begin
            seq_st   = ST_IDLE;
            tick_cnt = '0;
          end
        endcase
      end
      MODE_WARN: begin
        beep_freq = c.tone_freq_in;
        beep_on   = c.on_ms[TIME_BITS-1:0];
        beep_off  = c.off_ms[TIME_BITS-1:0];
        beeps_rem = c.repeat_count[REPEAT_BITS-1:0];
        if (seq_st == ST_IDLE) begin
          seq_st   = ST_START;
          tick_cnt = '0;
        end
      end
      MODE_KEY: begin
        beep_freq = c.tone_freq_in;
        beep_on   = c.on_ms[TIME_BITS-1:0];
        beep_off  = '0;
        beeps_rem = REP_ONE;
        seq_st    = ST_START;
        tick_cnt  = '0;
      end
      default: begin
        is_muted = c.mute_flag;
        if (c.mute_flag) tone_live = 1'b0;
      end
    endcase
    r.tone_on   = tone_live;
    r.tone_freq = tone_hz;
    r.busy_res  = (seq_st != ST_IDLE);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on each taken command word, check each taken result word
  always @(posedge clk) begin
    res_t got_r;
    res_t want_r;
    if (rst) begin
      seq_st    = ST_IDLE;
      tick_cnt  = '0;
      beep_freq = '0;
      beep_on   = '0;
      beep_off  = '0;
      beeps_rem = '0;
      is_muted  = 1'b0;
      tone_live = 1'b0;
      tone_hz   = '0;
      predicted_res.delete();
    end else begin
      if (cmd_valid && cmd_ready) begin
        step_sequencer(cmd, want_r);
        predicted_res.push_back(want_r);
      end
      if (res_valid && res_ready) begin
        got_r = res;
        if (predicted_res.size() == 0) begin
          report_mismatch("unexpected result word", got_r, 0);
        end else begin
          want_r = predicted_res.pop_front();
          if (got_r.tone_on !== want_r.tone_on)
            report_mismatch("tone_on", got_r.tone_on, want_r.tone_on);
          if (got_r.tone_freq !== want_r.tone_freq)
            report_mismatch("tone_freq", got_r.tone_freq, want_r.tone_freq);
          if (got_r.busy_res !== want_r.busy_res)
            report_mismatch("busy_res", got_r.busy_res, want_r.busy_res);
        end
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_en && $urandom_range(0, 7) == 0) begin
        res_ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        res_ready = 1'b1;
      end
    end
  end

  function automatic cmd_t make_word(mode_t m, logic [15:0] f, logic [15:0] on_t,
                                     logic [15:0] off_t, logic [7:0] reps, logic mf);
    cmd_t w;
    w.mode         = m;
    w.tone_freq_in = f;
    w.on_ms        = on_t;
    w.off_ms       = off_t;
    w.repeat_count = reps;
    w.mute_flag    = mf;
    return w;
  endfunction

  function automatic cmd_t rand_word(mode_t m);
    return make_word(m, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                     1'($urandom));
  endfunction

  // Drive one command word, with an optional random gap, and hold until taken
  task automatic send_word(input cmd_t w);
    @(negedge clk);
    if (gap_en && $urandom_range(0, 7) == 0) begin
      cmd_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    cmd       = w;
    cmd_valid = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(rand_word(MODE_TICK));
  endtask

  // Drop valid and hold off until every owed result word has come back
  task automatic wait_drained();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (predicted_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two beeps at top frequency, one tick on and one tick off, then done
  task automatic test_warn_two_beeps();
    send_word(make_word(MODE_WARN, 16'hFFFF, 16'd1, 16'd1, 8'd2, 1'b0));
    send_ticks(9);
  endtask

  // Zero frequency, muted start, mute while sounding, warn while busy, unmute
  task automatic test_key_mute_busy();
    send_word(make_word(MODE_MUTE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1));
    send_word(make_word(MODE_KEY, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 1'b1));
    send_ticks(1);
    send_word(make_word(MODE_MUTE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
    send_word(make_word(MODE_KEY, 16'h0000, 16'd3, 16'h0000, 8'h00, 1'b0));
    send_ticks(2);
    send_word(make_word(MODE_MUTE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1));
    send_word(make_word(MODE_WARN, 16'h1234, 16'd2, 16'd0, 8'd0, 1'b0));
    send_word(make_word(MODE_MUTE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0));
    send_ticks(6);
  endtask

  // Mostly well-formed patterns with random content, the rest noise
  task automatic test_random_patterns(input int n_words);
    cmd_t w;
    int   stop_at;
    int   n_ticks;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        w = rand_word($urandom_range(0, 1) ? MODE_WARN : MODE_KEY);
        if ($urandom_range(0, 15) != 0) w.on_ms = 16'($urandom_range(0, 6));
        if ($urandom_range(0, 15) != 0) w.off_ms = 16'($urandom_range(0, 6));
        if ($urandom_range(0, 9) != 0) w.repeat_count = 8'($urandom_range(0, 4));
        send_word(w);
        n_ticks = $urandom_range(0, 40);
        repeat (n_ticks) begin
          if ($urandom_range(0, 19) == 0) send_word(rand_word(MODE_MUTE));
          else send_word(rand_word(MODE_TICK));
        end
      end else begin
        send_word(rand_word(mode_t'($urandom_range(0, 3))));
      end
    end
  endtask

  // Run the tail back to back with both sides always ready
  task automatic test_no_idle_tail();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    test_random_patterns(40);
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    gap_en     = 1'b1;
    stall_en   = 1'b1;
    words_sent = 0;
    fail_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_warn_two_beeps();
    test_key_mute_busy();
    test_random_patterns(220);
    wait_drained();
    test_random_patterns(220);
    test_no_idle_tail();

    // Wait for the last result words to drain
    @(negedge clk);
    cmd_valid = 1'b0;
    while (predicted_res.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
